// File: rtl/core/cps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types, codes and constants of the compass pattern search sequencer.
// ----------------------------------------------------------------------------
package cps_pkg;

	localparam int PARAM_SLOTS = 8;
	localparam int VALUE_BITS  = 32;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_SCORE = 2'd2;

	localparam logic [1:0] KIND_TRIAL  = 2'd0;
	localparam logic [1:0] KIND_COMMIT = 2'd1;
	localparam logic [1:0] KIND_PASS   = 2'd2;
	localparam logic [1:0] KIND_DONE   = 2'd3;

	localparam logic CFG_MAX_CYCLES = 1'b0;
	localparam logic CFG_RESET_BEST = 1'b1;

	// datapath operations requested by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,       // write slot from input word
		OP_START,      // clear pass count and best, begin pass
		OP_NEXTPASS,   // start next pass
		OP_SEEK_SKIP,  // current group finished, advance
		OP_SEEK_OPEN,  // open current group, emit first trial
		OP_SCORE,      // fold in score, advance trial slot
		OP_COMMIT,     // commit group, emit commit
		OP_PASS_END,   // count pass
		OP_EMIT_PASS,  // emit pass finished
		OP_EMIT_DONE   // emit search finished
	} op_t;

	typedef struct packed {
		op_t  op;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic at_end;      // current_param beyond last slot
		logic grp_done;    // current group finished
		logic trials_left; // after score: more trials remain
		logic stop;        // after pass count: search ends
		logic zero_max;    // max_cycles is zero
	} stat_t;

endpackage : cps_pkg
`default_nettype wire

// File: rtl/core/cps_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cps_datapath
// Slot store, score compare, trial value generation and result register.
// ----------------------------------------------------------------------------
module cps_datapath #(
	parameter int PARAM_SLOTS = cps_pkg::PARAM_SLOTS,
	parameter int VALUE_BITS  = cps_pkg::VALUE_BITS
) (
	input  wire               clk,
	input  wire               arst_n,
	input  cps_pkg::cmd_t     cmd,
	input  wire  [2:0]        in_index,
	input  wire  [31:0]       in_value,
	input  wire  [30:0]       in_step,
	input  wire  [30:0]       in_tol,
	input  wire               in_coupled,
	input  wire  [31:0]       in_score,
	input  wire               in_invalid,
	input  wire  [15:0]       max_cycles,
	input  wire               reset_best,
	output cps_pkg::stat_t    stat,
	output logic [122:0]      res_q     // packed result word
);
	localparam int IW = (PARAM_SLOTS > 1) ? $clog2(PARAM_SLOTS) : 1;
	localparam int CW = $clog2(PARAM_SLOTS + 2);
	localparam logic signed [VALUE_BITS:0] VMAX = {2'b00, {(VALUE_BITS-1){1'b1}}};
	localparam logic signed [VALUE_BITS:0] VMIN = {2'b11, {(VALUE_BITS-1){1'b0}}};

	logic signed [VALUE_BITS-1:0] val_q [PARAM_SLOTS];
	logic [30:0] step_q [PARAM_SLOTS];
	logic [30:0] tol_q  [PARAM_SLOTS];
	logic [PARAM_SLOTS-1:0] pair_q;

	logic        best_max_q, gmin_max_q, all_fin_q;
	logic [31:0] best_q, gmin_q;
	logic [3:0]  gslot_q, tslot_q;
	logic [CW-1:0] cur_q;
	logic [15:0] passes_q;

	logic [IW-1:0] p, p1;
	logic is_pair, at_end;
	logic [CW:0] cur_ext;

	assign cur_ext = {1'b0, cur_q};
	assign at_end  = cur_ext >= (CW+1)'(PARAM_SLOTS);
	assign p       = at_end ? '0 : cur_q[IW-1:0];
	assign p1      = IW'(cur_ext + (CW+1)'(1));
	assign is_pair = !at_end && pair_q[p] && (cur_ext + (CW+1)'(1) < (CW+1)'(PARAM_SLOTS));

	function automatic logic signed [VALUE_BITS-1:0] offv(
		input logic signed [VALUE_BITS-1:0] v, input logic [30:0] s, input logic [1:0] k);
		logic signed [VALUE_BITS+31:0] t;
		t = $signed({{32{v[VALUE_BITS-1]}}, v});
		if (k == 2'd0) t = t - $signed({{VALUE_BITS{1'b0}}, 1'b0, s});
		else if (k == 2'd2) t = t + $signed({{VALUE_BITS{1'b0}}, 1'b0, s});
		if (t > $signed((VALUE_BITS+32)'(VMAX))) t = (VALUE_BITS+32)'(VMAX);
		if (t < $signed({{31{1'b1}}, VMIN})) t = {{31{1'b1}}, VMIN};
		return t[VALUE_BITS-1:0];
	endfunction

	// emitted slot: a pair opens at 0, a single at center, or minus with a best
	logic [3:0] tsel;
	assign tsel = (cmd.op == cps_pkg::OP_SEEK_OPEN)
		? (is_pair ? 4'd0 : {3'd0, best_max_q}) : tslot_q;

	logic [1:0] k1, k2, sk1, sk2;
	always_comb begin
		k1 = is_pair ? ((tsel >= 4'd6) ? 2'd2 : (tsel >= 4'd3) ? 2'd1 : 2'd0)
			: tsel[1:0];
		k2 = 2'(tsel - 4'd3 * {2'b0, k1});
		sk1 = is_pair ? ((gslot_q >= 4'd6) ? 2'd2 : (gslot_q >= 4'd3) ? 2'd1 : 2'd0)
			: gslot_q[1:0];
		sk2 = 2'(gslot_q - 4'd3 * {2'b0, sk1});
	end

	logic signed [VALUE_BITS-1:0] tv1, tv2, cv1, cv2;
	assign tv1 = offv(val_q[p], step_q[p], k1);
	assign tv2 = offv(val_q[p1], step_q[p1], k2);
	assign cv1 = offv(val_q[p], step_q[p], sk1);
	assign cv2 = offv(val_q[p1], step_q[p1], sk2);

	logic grp_done;
	assign grp_done = is_pair ? (step_q[p] < tol_q[p] && step_q[p1] < tol_q[p1])
		: (step_q[p] < tol_q[p]);

	logic better;
	assign better = !in_invalid && (gmin_max_q || $signed(in_score) < $signed(gmin_q));

	// single slot order: center, minus, plus; 3 marks the group complete
	logic [3:0] tnext;
	always_comb begin
		if (is_pair) tnext = tslot_q + 4'd1;
		else if (tslot_q == 4'd1) tnext = 4'd0;
		else if (tslot_q == 4'd0) tnext = 4'd2;
		else tnext = 4'd3;
	end

	assign stat.at_end      = at_end;
	assign stat.grp_done    = grp_done;
	assign stat.trials_left = is_pair ? (tslot_q < 4'd9) : (tslot_q != 4'd3);
	assign stat.stop        = all_fin_q || passes_q >= max_cycles;
	assign stat.zero_max    = max_cycles == 16'd0;

	// result word: kind, idx1, val1, pv, idx2, val2, best, is_max, passes, last
	function automatic logic [122:0] pack(input logic [1:0] kd, input logic [2:0] i1,
		input logic [31:0] v1, input logic pv, input logic [2:0] i2, input logic [31:0] v2,
		input logic bm, input logic [31:0] bs, input logic [15:0] pc, input logic lst);
		return {lst, pc, bm, (bm ? 32'h7FFF_FFFF : bs), v2, i2, pv, v1, i1, kd};
	endfunction

	logic signed [31:0] tv1w, tv2w, cv1w, cv2w;
	assign tv1w = 32'(tv1);
	assign tv2w = is_pair ? 32'(tv2) : 32'd0;
	assign cv1w = 32'(cv1);
	assign cv2w = is_pair ? 32'(cv2) : 32'd0;

	logic [2:0] i1w, i2w;
	assign i1w = 3'(p);
	assign i2w = is_pair ? 3'(p1) : 3'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= '0;
			best_max_q <= 1'b1;
			best_q <= '0;
			gmin_max_q <= 1'b1;
			gmin_q <= '0;
			gslot_q <= '0;
			tslot_q <= '0;
			cur_q <= '0;
			passes_q <= '0;
			all_fin_q <= 1'b1;
		end else begin
			unique case (cmd.op)
				cps_pkg::OP_LOAD: begin
					if (32'(in_index) < 32'(PARAM_SLOTS))
						pair_q[IW'(in_index)] <= in_coupled;
				end
				cps_pkg::OP_START: begin
					passes_q <= '0;
					best_max_q <= 1'b1;
					best_q <= '0;
					all_fin_q <= 1'b1;
					cur_q <= '0;
				end
				cps_pkg::OP_NEXTPASS: begin
					all_fin_q <= 1'b1;
					cur_q <= '0;
					if (reset_best) begin
						best_max_q <= 1'b1;
						best_q <= '0;
					end
				end
				cps_pkg::OP_SEEK_SKIP: cur_q <= cur_q + (is_pair ? CW'(2) : CW'(1));
				cps_pkg::OP_SEEK_OPEN: begin
					all_fin_q <= 1'b0;
					gmin_max_q <= best_max_q;
					gmin_q <= best_q;
					gslot_q <= is_pair ? 4'd4 : 4'd1;
					tslot_q <= tsel;
				end
				cps_pkg::OP_SCORE: begin
					if (better) begin
						gmin_max_q <= 1'b0;
						gmin_q <= in_score;
						gslot_q <= tslot_q;
					end
					tslot_q <= tnext;
				end
				cps_pkg::OP_COMMIT: begin
					best_max_q <= gmin_max_q;
					best_q <= gmin_q;
					cur_q <= cur_q + (is_pair ? CW'(2) : CW'(1));
				end
				cps_pkg::OP_PASS_END: passes_q <= passes_q + 16'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			cps_pkg::OP_LOAD: begin
				if (32'(in_index) < 32'(PARAM_SLOTS)) begin
					val_q[IW'(in_index)]  <= offv(VALUE_BITS'($signed(in_value)), 31'd0, 2'd1);
					step_q[IW'(in_index)] <= in_step;
					tol_q[IW'(in_index)]  <= in_tol;
				end
			end
			cps_pkg::OP_SEEK_OPEN:
				res_q <= pack(cps_pkg::KIND_TRIAL, i1w, tv1w, is_pair, i2w, tv2w,
					best_max_q, best_q, passes_q, cmd.last);
			cps_pkg::OP_SCORE:
				res_q <= res_q;
			cps_pkg::OP_COMMIT: begin
				val_q[p] <= cv1;
				if (is_pair) val_q[p1] <= cv2;
				if (gslot_q == (is_pair ? 4'd4 : 4'd1)) begin
					step_q[p] <= step_q[p] >> 1;
					if (is_pair) step_q[p1] <= step_q[p1] >> 1;
				end
				res_q <= pack(cps_pkg::KIND_COMMIT, i1w, cv1w, is_pair, i2w, cv2w,
					gmin_max_q, gmin_q, passes_q, cmd.last);
			end
			cps_pkg::OP_EMIT_PASS:
				res_q <= pack(cps_pkg::KIND_PASS, 3'd0, 32'd0, 1'b0, 3'd0, 32'd0,
					best_max_q, best_q, passes_q, cmd.last);
			cps_pkg::OP_EMIT_DONE:
				res_q <= pack(cps_pkg::KIND_DONE, 3'd0, 32'd0, 1'b0, 3'd0, 32'd0,
					best_max_q, best_q, passes_q, cmd.last);
			cps_pkg::OP_NONE: begin
				// after a score with trials left, emit next trial
				if (cmd.last)
					res_q <= pack(cps_pkg::KIND_TRIAL, i1w, tv1w, is_pair, i2w, tv2w,
						best_max_q, best_q, passes_q, 1'b1);
			end
			default: ;
		endcase
	end

endmodule : cps_datapath
`default_nettype wire

// File: rtl/core/cps_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cps_control
// Sequencer: accepts a word, steps the datapath, hands out results.
// ----------------------------------------------------------------------------
module cps_control (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  wire  [1:0]      in_cmd,
	input  cps_pkg::stat_t  stat,
	output cps_pkg::cmd_t   cmd,
	output logic            out_valid,
	input  wire             out_ready
);
	localparam logic [3:0] S_IDLE = 4'd0, S_SEEK = 4'd1, S_SCORE = 4'd2,
		S_AFTER = 4'd3, S_COMMIT = 4'd4, S_PEND = 4'd5, S_WAIT = 4'd6,
		S_START = 4'd7, S_NTRIAL = 4'd8;

	logic [3:0] state_q, state_d, ret_q, ret_d;
	logic       run_q, run_d, ov_q, ov_d;

	assign out_valid = ov_q;
	assign in_ready  = (state_q == S_IDLE) && !ov_q;

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		run_d = run_q;
		ov_d = ov_q && !out_ready;
		cmd.op = cps_pkg::OP_NONE;
		cmd.last = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					priority case (in_cmd)
						cps_pkg::CMD_LOAD: if (!run_q) cmd.op = cps_pkg::OP_LOAD;
						cps_pkg::CMD_START: begin
							cmd.op = cps_pkg::OP_START;
							state_d = S_START;
						end
						cps_pkg::CMD_SCORE: if (run_q) begin
							cmd.op = cps_pkg::OP_SCORE;
							state_d = S_AFTER;
						end
						default: ;
					endcase
				end
			end
			S_START: begin
				if (stat.zero_max) begin
					cmd.op = cps_pkg::OP_EMIT_DONE;
					cmd.last = 1'b1;
					ov_d = 1'b1;
					run_d = 1'b0;
					state_d = S_IDLE;
				end else begin
					run_d = 1'b1;
					state_d = S_SEEK;
				end
			end
			S_AFTER: begin
				if (stat.trials_left) begin
					cmd.last = 1'b1;
					ov_d = 1'b1;
					state_d = S_IDLE;
				end else state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.op = cps_pkg::OP_COMMIT;
				ov_d = 1'b1;
				state_d = S_WAIT;
				ret_d = S_SEEK;
			end
			S_SEEK: begin
				if (stat.at_end) begin
					cmd.op = cps_pkg::OP_PASS_END;
					state_d = S_PEND;
				end else if (stat.grp_done) cmd.op = cps_pkg::OP_SEEK_SKIP;
				else begin
					cmd.op = cps_pkg::OP_SEEK_OPEN;
					cmd.last = 1'b1;
					ov_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_PEND: begin
				if (stat.stop) begin
					cmd.op = cps_pkg::OP_EMIT_DONE;
					cmd.last = 1'b1;
					run_d = 1'b0;
					ov_d = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.op = cps_pkg::OP_EMIT_PASS;
					ov_d = 1'b1;
					state_d = S_WAIT;
					ret_d = S_NTRIAL;
				end
			end
			S_NTRIAL: begin
				cmd.op = cps_pkg::OP_NEXTPASS;
				state_d = S_SEEK;
			end
			S_WAIT: begin
				if (!ov_q) state_d = ret_q;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			run_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			run_q <= run_d;
			ov_q <= ov_d;
		end
	end

endmodule : cps_control
`default_nettype wire

// File: rtl/core/coordinate_pattern_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// coordinate_pattern_search
// Compass pattern search sequencer with step halving on Q16.16 values.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  s_axis   | in  | command word: tuser=command, tdata=load and score fields
//  m_axis   | out | result word: tuser=kind, tdata=indexes, values, best, count
//  cfg      | in  | index + data, reg 0 max_cycles, reg 1 reset_best_each_cycle
//
// A load or an ignored word leaves the block idle. A score with a trial left
// goes via the after-score state, which registers the next trial; else the
// commit state registers the commit. A taken commit word leads to seek, which
// skips finished groups and opens the next; the pass-end state registers the
// pass or done word, and a taken pass word leads via next-pass to seek. No
// word is taken while a result word waits. Reset spares slot values and steps.
// ----------------------------------------------------------------------------
module coordinate_pattern_search #(
	parameter int PARAM_SLOTS = cps_pkg::PARAM_SLOTS,
	parameter int VALUE_BITS  = cps_pkg::VALUE_BITS
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: param_index, load_value, load_step, load_tolerance, load_coupled,
	//        score, score_invalid
	input  wire  [135:0] s_axis_tdata,
	// tuser: command
	input  wire  [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// tdata: first_index, first_value, pair_valid, second_index, second_value,
	//        best_score, best_is_max, pass_count
	output logic [119:0] m_axis_tdata,
	// tuser: kind
	output logic [1:0]   m_axis_tuser,
	output logic         m_axis_tlast,
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire          cfg_index,
	input  wire  [15:0]  cfg_data
);
	cps_pkg::cmd_t  cmd;
	cps_pkg::stat_t stat;
	logic [122:0]   res;
	logic [15:0]    max_cycles_q;
	logic           reset_best_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cycles_q <= 16'd1;
			reset_best_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == cps_pkg::CFG_MAX_CYCLES) max_cycles_q <= cfg_data;
			else reset_best_q <= cfg_data[0];
		end
	end

	cps_control u_ctl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_cmd(s_axis_tuser), .stat(stat), .cmd(cmd),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready));

	cps_datapath #(.PARAM_SLOTS(PARAM_SLOTS), .VALUE_BITS(VALUE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_index(s_axis_tdata[2:0]), .in_value(s_axis_tdata[34:3]),
		.in_step(s_axis_tdata[65:35]), .in_tol(s_axis_tdata[96:66]),
		.in_coupled(s_axis_tdata[97]), .in_score(s_axis_tdata[129:98]),
		.in_invalid(s_axis_tdata[130]), .max_cycles(max_cycles_q),
		.reset_best(reset_best_q), .stat(stat), .res_q(res));

	assign m_axis_tuser = res[1:0];
	assign m_axis_tdata = res[121:2];
	assign m_axis_tlast = res[122];

endmodule : coordinate_pattern_search
`default_nettype wire

// File: rtl/core/cps_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cps_props
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module cps_props (
	input wire       clk,
	input wire       arst_n,
	input wire       s_axis_tready,
	input wire       m_axis_tvalid,
	input wire       m_axis_tready,
	input wire [1:0] m_axis_tuser,
	input wire       m_axis_tlast
);
	// no new word while a result waits
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");
	// search finished always closes the answer
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == cps_pkg::KIND_DONE |-> m_axis_tlast)
		else $error("done without last");
	// commit and pass words are followed by more
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == cps_pkg::KIND_COMMIT ||
		m_axis_tuser == cps_pkg::KIND_PASS) |-> !m_axis_tlast)
		else $error("last on intermediate word");
	// stalled output holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
		else $error("output dropped");
endmodule : cps_props

bind coordinate_pattern_search cps_props u_cps_props (
	.clk(clk), .arst_n(arst_n), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast));
`default_nettype wire

// File: sim/cps_checker.sv
// ----------------------------------------------------------------------------
// cps_checker
// Watches the command, result and config channels of the pattern search
// sequencer, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module cps_checker (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	input  wire          s_axis_tready,
	input  wire  [135:0] s_axis_tdata,
	input  wire  [1:0]   s_axis_tuser,
	input  wire          m_axis_tvalid,
	input  wire          m_axis_tready,
	input  wire  [119:0] m_axis_tdata,
	input  wire  [1:0]   m_axis_tuser,
	input  wire          m_axis_tlast,
	input  wire          cfg_valid,
	input  wire          cfg_ready,
	input  wire          cfg_index,
	input  wire  [15:0]  cfg_data,
	output int           fails,
	output int           pending
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  i1;
		logic [31:0] v1;
		logic        pv;
		logic [2:0]  i2;
		logic [31:0] v2;
		logic [31:0] best;
		logic        bmax;
		logic [15:0] passes;
		logic        last;
	} result_t;

	result_t result_q[$];

	// sequencer state
	logic [31:0] pval [8];
	logic [31:0] step [8];
	logic [31:0] tol  [8];
	logic        pair [8];
	logic        best_max, gmin_max;
	logic [31:0] best_v, gmin_v;
	int          gslot, tslot, cur;
	logic [15:0] passes;
	logic        all_fin, running;
	logic [15:0] max_passes;
	logic        forget_best;

	function automatic logic [31:0] sat(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fff_ffff;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic bit is_pair(int p);
		return pair[p] && p < 7;
	endfunction

	function automatic bit grp_done(int p);
		if (is_pair(p))
			return step[p] < tol[p] && step[p+1] < tol[p+1];
		return step[p] < tol[p];
	endfunction

	function automatic logic [31:0] trial_value(int p, int k);
		longint b;
		longint s;
		b = longint'($signed(pval[p]));
		s = longint'(step[p]);
		if (k == 0)
			return sat(b - s);
		if (k == 2)
			return sat(b + s);
		return pval[p];
	endfunction

	task automatic push(logic [1:0] kind, int i1, logic [31:0] v1, logic pv, int i2,
			logic [31:0] v2);
		result_t r;
		r.kind = kind;
		r.i1 = i1[2:0];
		r.v1 = v1;
		r.pv = pv;
		r.i2 = i2[2:0];
		r.v2 = v2;
		r.best = best_max ? 32'h7fff_ffff : best_v;
		r.bmax = best_max;
		r.passes = passes;
		r.last = 1'b0;
		result_q.push_back(r);
	endtask

	task automatic push_trial();
		if (is_pair(cur))
			push(cps_pkg::KIND_TRIAL, cur, trial_value(cur, tslot / 3), 1'b1, cur + 1,
				trial_value(cur + 1, tslot % 3));
		else
			push(cps_pkg::KIND_TRIAL, cur, trial_value(cur, tslot), 1'b0, 0, '0);
	endtask

	task automatic begin_pass();
		all_fin = 1'b1;
		if (forget_best)
			best_max = 1'b1;
		if (forget_best)
			best_v = '0;
		cur = 0;
	endtask

	// walk to the next open group, closing passes on the way
	task automatic find_group();
		bit found;
		found = 0;
		while (!found) begin
			if (cur < 8) begin
				if (grp_done(cur)) begin
					cur += is_pair(cur) ? 2 : 1;
				end else begin
					all_fin = 1'b0;
					gmin_max = best_max;
					gmin_v = best_v;
					gslot = is_pair(cur) ? 4 : 1;
					tslot = is_pair(cur) ? 0 : (best_max ? 1 : 0);
					push_trial();
					found = 1;
				end
			end else begin
				passes = passes + 16'd1;
				if (all_fin || passes >= max_passes) begin
					running = 1'b0;
					push(cps_pkg::KIND_DONE, 0, '0, 1'b0, 0, '0);
					found = 1;
				end else begin
					push(cps_pkg::KIND_PASS, 0, '0, 1'b0, 0, '0);
					begin_pass();
				end
			end
		end
	endtask

	task automatic take_score(logic [31:0] sc, logic inv);
		int p;
		bit pr;
		logic [31:0] a, b;
		p = cur;
		pr = is_pair(p);
		if (!inv && (gmin_max || $signed(sc) < $signed(gmin_v))) begin
			gmin_max = 1'b0;
			gmin_v = sc;
			gslot = tslot;
		end
		if (pr) begin
			tslot++;
			if (tslot < 9) begin
				push_trial();
				return;
			end
		end else if (tslot == 1) begin
			tslot = 0;
			push_trial();
			return;
		end else if (tslot == 0) begin
			tslot = 2;
			push_trial();
			return;
		end
		best_max = gmin_max;
		best_v = gmin_max ? 32'd0 : gmin_v;
		if (pr) begin
			a = trial_value(p, gslot / 3);
			b = trial_value(p + 1, gslot % 3);
			pval[p] = a;
			pval[p+1] = b;
			if (gslot == 4) begin
				step[p] = step[p] >> 1;
				step[p+1] = step[p+1] >> 1;
			end
			push(cps_pkg::KIND_COMMIT, p, a, 1'b1, p + 1, b);
			cur = p + 2;
		end else begin
			a = trial_value(p, gslot);
			pval[p] = a;
			if (gslot == 1)
				step[p] = step[p] >> 1;
			push(cps_pkg::KIND_COMMIT, p, a, 1'b0, 0, '0);
			cur = p + 1;
		end
		find_group();
	endtask

	task automatic take_word(logic [1:0] cmd, logic [135:0] d);
		int n0;
		result_t r;
		n0 = result_q.size();
		case (cmd)
			cps_pkg::CMD_LOAD: begin
				if (!running) begin
					pval[d[2:0]] = d[34:3];
					step[d[2:0]] = {1'b0, d[65:35]};
					tol[d[2:0]] = {1'b0, d[96:66]};
					pair[d[2:0]] = d[97];
				end
			end
			cps_pkg::CMD_START: begin
				passes = '0;
				best_max = 1'b1;
				best_v = '0;
				running = 1'b1;
				if (max_passes == 0) begin
					running = 1'b0;
					push(cps_pkg::KIND_DONE, 0, '0, 1'b0, 0, '0);
				end else begin
					begin_pass();
					find_group();
				end
			end
			cps_pkg::CMD_SCORE: begin
				if (running)
					take_score(d[129:98], d[130]);
			end
			default: ;
		endcase
		if (result_q.size() > n0) begin
			r = result_q.pop_back();
			r.last = 1'b1;
			result_q.push_back(r);
		end
	endtask

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			fails++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				pval[i] = '0;
				step[i] = '0;
				tol[i] = '0;
				pair[i] = 1'b0;
			end
			best_max = 1'b1;
			best_v = '0;
			gmin_max = 1'b1;
			gmin_v = '0;
			gslot = 0;
			tslot = 0;
			cur = 0;
			passes = '0;
			all_fin = 1'b1;
			running = 1'b0;
			max_passes = 16'd1;
			forget_best = 1'b0;
			fails = 0;
			result_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == cps_pkg::CFG_MAX_CYCLES)
					max_passes = cfg_data;
				else
					forget_best = cfg_data[0];
			end
			if (s_axis_tvalid && s_axis_tready)
				take_word(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (result_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected result word, expected none, got %h/%h", $time,
						m_axis_tuser, m_axis_tdata);
				end else begin
					e = result_q.pop_front();
					check_field("kind", e.kind, m_axis_tuser);
					check_field("first_index", e.i1, m_axis_tdata[2:0]);
					check_field("first_value", e.v1, m_axis_tdata[34:3]);
					check_field("pair_valid", e.pv, m_axis_tdata[35]);
					check_field("second_index", e.i2, m_axis_tdata[38:36]);
					check_field("second_value", e.v2, m_axis_tdata[70:39]);
					check_field("best_score", e.best, m_axis_tdata[102:71]);
					check_field("best_is_max", e.bmax, m_axis_tdata[103]);
					check_field("pass_count", e.passes, m_axis_tdata[119:104]);
					check_field("last", e.last, m_axis_tlast);
				end
			end
		end
		pending = result_q.size();
	end

endmodule : cps_checker

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives load, start and score words into the pattern search sequencer,
// answering each trial like an outside evaluator, and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [1:0] CMD_NOP = 2'd3; // unused code, block ignores it
	localparam int LIMIT = 3000000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// tdata: param_index, load_value, load_step, load_tolerance, load_coupled,
	//        score, score_invalid
	logic [135:0] s_axis_tdata;
	// tuser: command
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// tdata: first_index, first_value, pair_valid, second_index, second_value,
	//        best_score, best_is_max, pass_count
	logic [119:0] m_axis_tdata;
	// tuser: kind
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_index;
	logic [15:0]  cfg_data;

	int fails, pending;
	int send_idle_pct, recv_stall_pct;
	int replies = 0;      // tlast words taken
	logic [1:0] reply_kind = cps_pkg::KIND_TRIAL; // kind of the latest tlast word
	int cycles;
	int items;
	bit running;
	bit all_invalid;      // evaluator answers every trial with an invalid score

	coordinate_pattern_search u_top (.*);

	cps_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// receiver side: random stall per cycle
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	// count the closing word of each answer
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready && m_axis_tlast) begin
			replies <= replies + 1;
			reply_kind <= m_axis_tuser;
		end
	end

	// one input word; valid stays high until the caller drops it
	task automatic send(logic [1:0] cmd, logic [2:0] idx, logic [31:0] val, logic [30:0] stp,
			logic [30:0] tl, logic cpl, logic [31:0] sc, logic inv);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {5'd0, inv, sc, cpl, tl, stp, val, idx};
		do @(posedge clk); while (!s_axis_tready);
		if (cmd != CMD_NOP)
			items++;
	endtask

	// drop valid and wait for the answer to close with tlast
	task automatic await_reply(int prev_replies);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (replies == prev_replies);
		running = (reply_kind != cps_pkg::KIND_DONE);
	endtask

	task automatic load(int idx, logic [31:0] val, logic [30:0] stp, logic [30:0] tl,
			logic cpl);
		send(cps_pkg::CMD_LOAD, idx[2:0], val, stp, tl, cpl, $urandom,
			1'($urandom_range(1)));
	endtask

	task automatic start();
		int prev_replies;
		prev_replies = replies;
		send(cps_pkg::CMD_START, 3'($urandom), $urandom, 31'($urandom), 31'($urandom),
			1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
		await_reply(prev_replies);
	endtask

	task automatic score();
		int prev_replies;
		logic [31:0] sc;
		logic inv;
		prev_replies = replies;
		// narrow scores make ties common
		sc = $urandom_range(3) == 0 ? $urandom : $urandom_range(6);
		inv = all_invalid || $urandom_range(7) == 0;
		send(cps_pkg::CMD_SCORE, 3'($urandom), $urandom, 31'($urandom), 31'($urandom),
			1'($urandom_range(1)), sc, inv);
		await_reply(prev_replies);
	endtask

	// block idle: quiet the input, let a skipped-group walk settle
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		repeat (40) @(posedge clk);
	endtask

	task automatic cfg_write(logic idx, logic [15:0] d);
		s_axis_tvalid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_load(int idx, bit quick);
		logic [30:0] stp;
		logic [30:0] tl;
		logic [31:0] val;
		val = $urandom_range(4) == 0 ? ($urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000)
			: $urandom;
		stp = $urandom_range(7) == 0 ? 31'($urandom) : 31'($urandom_range(1, 15) <<
			$urandom_range(0, 16));
		tl = stp >> $urandom_range(0, 3);
		if (!quick && $urandom_range(9) == 0)
			tl = 31'($urandom);
		if ($urandom_range(5) == 0)
			tl = stp + 31'd1; // already finished
		load(idx, val, stp, tl, $urandom_range(2) == 0);
	endtask

	// one search: scores until the done word, with a little noise mixed in
	task automatic run_search(bit noise);
		start();
		while (running) begin
			if (noise && $urandom_range(29) == 0) begin
				case ($urandom_range(2))
					0: random_load(int'($urandom_range(7)), 1'b0); // ignored while busy
					1: send(CMD_NOP, 3'($urandom), $urandom, 31'($urandom), 31'($urandom),
						1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
					default: start();  // restart from the stored values
				endcase
			end else begin
				score();
			end
		end
		settle();
	endtask

	initial begin
		int search_no;
		logic [15:0] passes_cfg;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = cps_pkg::CMD_LOAD;
		cfg_valid = 1'b0;
		cfg_index = cps_pkg::CFG_MAX_CYCLES;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		items = 0;
		running = 0;
		all_invalid = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: score and unused code while idle, then field extremes
		send(cps_pkg::CMD_SCORE, 3'd0, 32'd0, 31'd0, 31'd0, 1'b0, 32'h8000_0000, 1'b0);
		send(CMD_NOP, 3'd7, 32'hffff_ffff, '1, '1, 1'b1, 32'hffff_ffff, 1'b1);
		load(0, 32'h7fff_ffff, 31'h7fff_ffff, 31'd0, 1'b0);  // plus saturates
		load(1, 32'h8000_0000, 31'h7fff_ffff, 31'd0, 1'b0);  // minus saturates
		load(2, 32'h0001_0000, 31'h0000_8000, 31'h0000_1000, 1'b1); // pair 2-3
		load(3, 32'hffff_0000, 31'h0000_4000, 31'h0000_1000, 1'b1); // flag ignored
		load(4, 32'd0, 31'd0, 31'd0, 1'b0);                  // never finishes
		load(5, 32'd5, 31'd5, 31'h7fff_ffff, 1'b0);          // finished at once
		load(6, 32'h1234_5678, 31'h100, 31'h40, 1'b0);
		load(7, 32'h0000_0100, 31'h80, 31'h10, 1'b1);        // pair on last slot
		// reset config: one pass
		run_search(0);
		cfg_write(cps_pkg::CFG_MAX_CYCLES, 16'd0);
		start();
		settle();
		cfg_write(cps_pkg::CFG_MAX_CYCLES, 16'd3);
		cfg_write(cps_pkg::CFG_RESET_BEST, 16'd1);
		start();
		score();
		score();
		random_load(4, 1); // ignored while busy
		start();
		while (running)
			score();
		settle();
		cfg_write(cps_pkg::CFG_RESET_BEST, 16'd0);

		// random part
		search_no = 0;
		while (items < 500) begin
			case ((search_no / 2) % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			all_invalid = 0;
			if ($urandom_range(9) == 0) begin
				// long pass budget: only with slots that close in a few halvings
				passes_cfg = 16'hffff;
				all_invalid = 1;
				for (int i = 0; i < 8; i++)
					load(i, $urandom, 31'($urandom_range(1, 15) << 4), 31'd32,
						1'($urandom_range(1)));
			end else begin
				passes_cfg = $urandom_range(9) == 0 ? 16'd0 : 16'($urandom_range(1, 3));
				repeat ($urandom_range(0, 4))
					random_load(int'($urandom_range(7)), 1'b1);
			end
			cfg_write(cps_pkg::CFG_MAX_CYCLES, passes_cfg);
			if ($urandom_range(2) == 0)
				cfg_write(cps_pkg::CFG_RESET_BEST, 16'($urandom_range(1)));
			run_search(1);
			search_no++;
		end

		settle();
		repeat (200) begin
			if (pending == 0)
				break;
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule : testbench
